/* hw/rtl/twc_pkg.sv */
// Shared constants, types and hash helpers for the tiled cellular noise block.
`timescale 1ns / 1ps
package twc_pkg;

  localparam int FRAC_BITS = 16;
  localparam int CELL_BITS = 8;
  localparam int POS_W     = CELL_BITS + FRAC_BITS;
  localparam int PER_W     = 9;
  localparam int SEED_W    = 32;
  localparam int OUT_W     = FRAC_BITS + 1;
  localparam int NUM_AX    = 3;
  localparam int NUM_CELLS = 27;

  // z * per_y, then (.. + y) * per_x
  localparam int PROD_W = 2 * PER_W;
  localparam int IDX_W  = 3 * PER_W + 1;

  // signed axis difference, its magnitude, square and the 3-axis sum
  localparam int DIFF_W = FRAC_BITS + 2;
  localparam int MAG_W  = FRAC_BITS + 1;
  localparam int SQR_W  = 2 * MAG_W;
  localparam int SQ_W   = SQR_W + 2;
  localparam int BEST_W = 2 * FRAC_BITS + 1;

  localparam logic [BEST_W-1:0] ONE_SQ = BEST_W'(1) << (2 * FRAC_BITS);
  localparam logic [OUT_W-1:0]  ONE_FIX = OUT_W'(1) << FRAC_BITS;

  localparam logic [31:0] HASH_C1 = 32'h7feb352d;
  localparam logic [31:0] HASH_C2 = 32'h846ca68b;

  // neighbor offset along one axis: -1, 0, +1
  typedef enum logic [1:0] {
    OFS_NEG  = 2'd0,
    OFS_ZERO = 2'd1,
    OFS_POS  = 2'd2
  } ofs_t;

  typedef struct packed {
    ofs_t dz;
    ofs_t dy;
    ofs_t dx;
  } cell_ofs_t;

  // word handed from cell to cell: wrapped coords per axis and offset
  typedef struct packed {
    logic [NUM_AX-1:0][2:0][PER_W-1:0] wv;
    logic [PER_W-1:0]                  per_x;
    logic [PER_W-1:0]                  per_y;
    logic [SEED_W-1:0]                 seed;
    logic [NUM_AX-1:0][FRAC_BITS-1:0]  frac;
  } chain_t;

  function automatic logic [31:0] hash_mix_a(input logic [31:0] v);
    logic [31:0] t;
    t = v ^ (v >> 16);
    return t * HASH_C1;
  endfunction

  function automatic logic [31:0] hash_mix_b(input logic [31:0] v);
    logic [31:0] t;
    t = v ^ (v >> 15);
    return t * HASH_C2;
  endfunction

  function automatic logic [31:0] hash_fold(input logic [31:0] v);
    return v ^ (v >> 16);
  endfunction

endpackage

/* hw/rtl/twc_wrap.sv */
// Front end: pipelined tile-mod-period per axis and the -1/0/+1 neighbor wraps.
`timescale 1ns / 1ps
module twc_wrap
  import twc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              vld_in,
  input  logic [POS_W-1:0]  pos_x,
  input  logic [POS_W-1:0]  pos_y,
  input  logic [POS_W-1:0]  pos_z,
  input  logic [SEED_W-1:0] seed,
  input  logic [PER_W-1:0]  period_x,
  input  logic [PER_W-1:0]  period_y,
  input  logic [PER_W-1:0]  period_z,
  output logic              vld_out,
  output chain_t            chain_out
);

  typedef struct packed {
    logic [NUM_AX-1:0][PER_W-1:0]     rem;
    logic [NUM_AX-1:0][CELL_BITS-1:0] tile;
    logic [NUM_AX-1:0][PER_W-1:0]     per;
    logic [NUM_AX-1:0][FRAC_BITS-1:0] frac;
    logic [SEED_W-1:0]                seed;
  } div_t;

  div_t div_q [CELL_BITS];
  logic vld_q [CELL_BITS];
  div_t first;

  always_comb begin
    first.rem     = '0;
    first.tile[0] = pos_x[POS_W-1:FRAC_BITS];
    first.tile[1] = pos_y[POS_W-1:FRAC_BITS];
    first.tile[2] = pos_z[POS_W-1:FRAC_BITS];
    first.frac[0] = pos_x[FRAC_BITS-1:0];
    first.frac[1] = pos_y[FRAC_BITS-1:0];
    first.frac[2] = pos_z[FRAC_BITS-1:0];
    // a zero period acts as one
    first.per[0]  = (period_x == '0) ? PER_W'(1) : period_x;
    first.per[1]  = (period_y == '0) ? PER_W'(1) : period_y;
    first.per[2]  = (period_z == '0) ? PER_W'(1) : period_z;
    first.seed    = seed;
  end

  // restoring remainder, one tile bit per stage, MSB first
  for (genvar s = 0; s < CELL_BITS; s++) begin : g_div
    localparam int J = CELL_BITS - 1 - s;
    div_t src;
    logic src_vld;
    div_t nxt;

    if (s == 0) begin : g_head
      assign src     = first;
      assign src_vld = vld_in;
    end else begin : g_body
      assign src     = div_q[s-1];
      assign src_vld = vld_q[s-1];
    end

    always_comb begin
      logic [PER_W:0] t;
      nxt = src;
      for (int a = 0; a < NUM_AX; a++) begin
        t = {src.rem[a], src.tile[a][J]};
        if (t >= {1'b0, src.per[a]}) begin
          nxt.rem[a] = PER_W'(t - {1'b0, src.per[a]});
        end else begin
          nxt.rem[a] = t[PER_W-1:0];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= src_vld;
      end
      div_q[s] <= nxt;
    end
  end

  div_t last;
  assign last = div_q[CELL_BITS-1];

  always_ff @(posedge clk) begin
    logic [PER_W:0] inc;
    if (rst) begin
      vld_out <= 1'b0;
    end else begin
      vld_out <= vld_q[CELL_BITS-1];
    end
    for (int a = 0; a < NUM_AX; a++) begin
      inc = {1'b0, last.rem[a]} + (PER_W+1)'(1);
      chain_out.wv[a][OFS_ZERO] <= last.rem[a];
      chain_out.wv[a][OFS_NEG]  <= (last.rem[a] == '0) ? last.per[a] - PER_W'(1)
                                                       : last.rem[a] - PER_W'(1);
      chain_out.wv[a][OFS_POS]  <= (inc == {1'b0, last.per[a]}) ? '0 : inc[PER_W-1:0];
    end
    chain_out.per_x <= last.per[0];
    chain_out.per_y <= last.per[1];
    chain_out.seed  <= last.seed;
    chain_out.frac  <= last.frac;
  end

endmodule

/* hw/rtl/twc_cell.sv */
// One neighbor cell: index, triple hash, squared distance, running minimum.
`timescale 1ns / 1ps
module twc_cell
  import twc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  cell_ofs_t         ofs,
  input  logic              vld_in,
  input  chain_t            chain_in,
  input  logic [BEST_W-1:0] min_in,
  output logic              vld_out,
  output chain_t            chain_out,
  output logic              min_vld,
  output logic [BEST_W-1:0] min_out
);

  localparam int NSTG = 11;
  localparam logic signed [DIFF_W-1:0] ONE_S = DIFF_W'(1) << FRAC_BITS;

  function automatic logic [MAG_W-1:0] axis_mag(input logic [FRAC_BITS-1:0] fr,
                                                input logic [FRAC_BITS-1:0] off,
                                                input ofs_t o);
    logic signed [DIFF_W-1:0] d;
    d = $signed({2'b00, fr}) - $signed({2'b00, off});
    unique case (o)
      OFS_NEG:  d = d + ONE_S;
      OFS_POS:  d = d - ONE_S;
      OFS_ZERO: d = d;
      default:  d = d;
    endcase
    if (d < 0) d = -d;
    return d[MAG_W-1:0];
  endfunction

  chain_t pl;
  logic [NSTG-1:0] sv;

  logic [PROD_W-1:0] s0_a;
  logic [PER_W-1:0]  s0_w1, s0_w0, s0_px;
  logic [IDX_W-1:0]  s1_b;
  logic [PER_W-1:0]  s1_w0;
  logic [SEED_W-1:0] s0_seed, s1_seed;
  logic [31:0]       s2_r, s3_r, s4_r, s5_r, s6_r, s7_r;
  logic [FRAC_BITS-1:0] off0, off0_b, off0_c, off0_d, off0_e;
  logic [FRAC_BITS-1:0] off1, off1_b, off1_c;
  logic [FRAC_BITS-1:0] off2;
  logic [NUM_AX-1:0][FRAC_BITS-1:0] fr [NSTG-2];
  logic [NUM_AX-1:0][SQR_W-1:0] sqr;
  logic [SQ_W-1:0]   sq;
  logic [PROD_W:0]   aw;
  logic [31:0]       h0, h1, h2;

  assign chain_out = pl;
  assign aw = {1'b0, s0_a} + PROD_W'(s0_w1);
  assign h0 = hash_fold(s3_r);
  assign h1 = hash_fold(s5_r);
  assign h2 = hash_fold(s7_r);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_out <= 1'b0;
      sv      <= '0;
      min_vld <= 1'b0;
    end else begin
      vld_out <= vld_in;
      sv      <= {sv[NSTG-2:0], vld_out};
      min_vld <= sv[NSTG-1];
    end
  end

  always_ff @(posedge clk) begin
    pl <= chain_in;
    // index = (z * per_y + y) * per_x + x
    s0_a    <= PROD_W'(pl.wv[2][ofs.dz]) * PROD_W'(pl.per_y);
    s0_w1   <= pl.wv[1][ofs.dy];
    s0_w0   <= pl.wv[0][ofs.dx];
    s0_px   <= pl.per_x;
    s0_seed <= pl.seed;
    fr[0]   <= pl.frac;
    s1_b    <= IDX_W'(aw) * IDX_W'(s0_px);
    s1_w0   <= s0_w0;
    s1_seed <= s0_seed;
    for (int i = 1; i < NSTG - 2; i++) fr[i] <= fr[i-1];
    s2_r <= hash_mix_a(s1_seed + 32'(s1_b) + 32'(s1_w0));
    s3_r <= hash_mix_b(s2_r);
    s4_r <= hash_mix_a(h0);
    off0 <= h0[31 -: FRAC_BITS];
    s5_r <= hash_mix_b(s4_r);
    off0_b <= off0;
    s6_r <= hash_mix_a(h1);
    off1 <= h1[31 -: FRAC_BITS];
    off0_c <= off0_b;
    s7_r <= hash_mix_b(s6_r);
    off1_b <= off1;
    off0_d <= off0_c;
    off2 <= h2[31 -: FRAC_BITS];
    off1_c <= off1_b;
    off0_e <= off0_d;
    sqr[0] <= SQR_W'(axis_mag(fr[NSTG-3][0], off0_e, ofs.dx))
            * SQR_W'(axis_mag(fr[NSTG-3][0], off0_e, ofs.dx));
    sqr[1] <= SQR_W'(axis_mag(fr[NSTG-3][1], off1_c, ofs.dy))
            * SQR_W'(axis_mag(fr[NSTG-3][1], off1_c, ofs.dy));
    sqr[2] <= SQR_W'(axis_mag(fr[NSTG-3][2], off2, ofs.dz))
            * SQR_W'(axis_mag(fr[NSTG-3][2], off2, ofs.dz));
    sq <= SQ_W'(sqr[0]) + SQ_W'(sqr[1]) + SQ_W'(sqr[2]);
    min_out <= (sq < SQ_W'(min_in)) ? BEST_W'(sq) : min_in;
  end

endmodule

/* hw/rtl/twc_isqrt.sv */
// Pipelined integer square root, one root bit per stage.
`timescale 1ns / 1ps
module twc_isqrt
  import twc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              vld_in,
  input  logic [BEST_W-1:0] value,
  output logic              vld_out,
  output logic [OUT_W-1:0]  root
);

  localparam int TW = 2 * OUT_W + 1;

  logic [BEST_W-1:0] rem_q  [OUT_W];
  logic [OUT_W-1:0]  root_q [OUT_W];
  logic              vld_q  [OUT_W];

  for (genvar s = 0; s < OUT_W; s++) begin : g_stg
    localparam int B = OUT_W - 1 - s;
    logic [BEST_W-1:0] rem_src;
    logic [OUT_W-1:0]  root_src;
    logic              vld_src;
    logic [TW-1:0]     term;

    if (s == 0) begin : g_head
      assign rem_src  = value;
      assign root_src = '0;
      assign vld_src  = vld_in;
    end else begin : g_body
      assign rem_src  = rem_q[s-1];
      assign root_src = root_q[s-1];
      assign vld_src  = vld_q[s-1];
    end

    // (r + 2^B)^2 - r^2 = r * 2^(B+1) + 2^(2B)
    assign term = (TW'(root_src) << (B + 1)) | (TW'(1) << (2 * B));

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= vld_src;
      end
      if (TW'(rem_src) >= term) begin
        rem_q[s]  <= BEST_W'(TW'(rem_src) - term);
        root_q[s] <= root_src | (OUT_W'(1) << B);
      end else begin
        rem_q[s]  <= rem_src;
        root_q[s] <= root_src;
      end
    end
  end

  assign vld_out = vld_q[OUT_W-1];
  assign root    = root_q[OUT_W-1];

endmodule

/* hw/rtl/tiled_worley_cell_noise_3d.sv */
// Top level: tileable 3D cellular noise, front wrap, 27-cell chain, square root.
//
//  channel  | handshake          | words
//  ---------+--------------------+------------------------------------------------
//  input    | start / busy       | pos_x pos_y pos_z seed period_x period_y period_z
//  result   | done (strobe)      | nearest_distance
//
// One word is taken every clock; busy stays low. The path runs through the per-axis
// modulo pipeline (one tile bit per stage), the 27-cell chain (one cell per neighbor,
// each with a 12-stage hash/distance pipe) and the root (one bit per stage). Reset
// clears only valid bits.
`timescale 1ns / 1ps
module tiled_worley_cell_noise_3d
  import twc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [POS_W-1:0]  pos_x,
  input  logic [POS_W-1:0]  pos_y,
  input  logic [POS_W-1:0]  pos_z,
  input  logic [SEED_W-1:0] seed,
  input  logic [PER_W-1:0]  period_x,
  input  logic [PER_W-1:0]  period_y,
  input  logic [PER_W-1:0]  period_z,
  output logic              done,
  output logic [OUT_W-1:0]  nearest_distance
);

  chain_t            ch     [NUM_CELLS];
  logic              ch_vld [NUM_CELLS];
  logic [BEST_W-1:0] mn     [NUM_CELLS];
  logic              mn_vld;
  logic [OUT_W-1:0]  root;

  assign busy = 1'b0;

  twc_wrap u_wrap (
    .clk       (clk),
    .rst       (rst),
    .vld_in    (start),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .pos_z     (pos_z),
    .seed      (seed),
    .period_x  (period_x),
    .period_y  (period_y),
    .period_z  (period_z),
    .vld_out   (ch_vld[0]),
    .chain_out (ch[0])
  );

  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    cell_ofs_t         ofs;
    logic [BEST_W-1:0] min_src;

    assign ofs.dx = ofs_t'(2'(k % 3));
    assign ofs.dy = ofs_t'(2'((k / 3) % 3));
    assign ofs.dz = ofs_t'(2'(k / 9));

    if (k == 0) begin : g_head
      assign min_src = ONE_SQ;
    end else begin : g_body
      assign min_src = mn[k-1];
    end

    if (k < NUM_CELLS - 1) begin : g_mid
      twc_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .ofs       (ofs),
        .vld_in    (ch_vld[k]),
        .chain_in  (ch[k]),
        .min_in    (min_src),
        .vld_out   (ch_vld[k+1]),
        .chain_out (ch[k+1]),
        .min_vld   (),
        .min_out   (mn[k])
      );
    end else begin : g_tail
      twc_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .ofs       (ofs),
        .vld_in    (ch_vld[k]),
        .chain_in  (ch[k]),
        .min_in    (min_src),
        .vld_out   (),
        .chain_out (),
        .min_vld   (mn_vld),
        .min_out   (mn[k])
      );
    end
  end

  twc_isqrt u_isqrt (
    .clk     (clk),
    .rst     (rst),
    .vld_in  (mn_vld),
    .value   (mn[NUM_CELLS-1]),
    .vld_out (done),
    .root    (root)
  );

  // distance is capped at 1.0
  assign nearest_distance = (root > ONE_FIX) ? ONE_FIX : root;

endmodule

/* tb/sv/tb.sv */
// Self-checking testbench for the tiled 3D cellular noise block.
`timescale 1ns / 1ps
module tb;
  import twc_pkg::*;

  typedef struct {
    logic [POS_W-1:0]  px, py, pz;
    logic [SEED_W-1:0] sd;
    logic [PER_W-1:0]  prx, pry, prz;
  } voxel_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy, done;
  logic [POS_W-1:0]  pos_x = '0, pos_y = '0, pos_z = '0;
  logic [SEED_W-1:0] seed = '0;
  logic [PER_W-1:0]  period_x = '0, period_y = '0, period_z = '0;
  logic [OUT_W-1:0]  nearest_distance;

  voxel_t voxel_q[$];
  logic [OUT_W-1:0] dist_q[$];
  int errors = 0;
  int send_idle = 14;
  bit hold_send = 0;
  bit feeding = 0;

  tiled_worley_cell_noise_3d uut (.*);

  always #5 clk = ~clk;

  function automatic logic [31:0] lowbias(input logic [31:0] v);
    v = v ^ (v >> 16);
    v = v * 32'h7feb352d;
    v = v ^ (v >> 15);
    v = v * 32'h846ca68b;
    return v ^ (v >> 16);
  endfunction

  function automatic longint wrap_mod(input longint c, input longint p);
    longint r;
    r = c % p;
    if (r < 0) r += p;
    return r;
  endfunction

  function automatic logic [OUT_W-1:0] nearest_feature(input voxel_t v);
    longint tl[3], fr[3], pr[3], w[3], d[3];
    longint diff;
    logic [63:0] bestsq, sq, a, rem, root, bit_;
    logic [31:0] h[3], idx;
    logic [POS_W-1:0] p[3];
    logic [PER_W-1:0] q[3];
    p[0] = v.px; p[1] = v.py; p[2] = v.pz;
    q[0] = v.prx; q[1] = v.pry; q[2] = v.prz;
    for (int i = 0; i < 3; i++) begin
      tl[i] = p[i] >> FRAC_BITS;
      fr[i] = p[i] & ((1 << FRAC_BITS) - 1);
      pr[i] = (q[i] == 0) ? 1 : q[i];
    end
    bestsq = 64'd1 << (2 * FRAC_BITS);
    for (int dz = -1; dz <= 1; dz++)
      for (int dy = -1; dy <= 1; dy++)
        for (int dx = -1; dx <= 1; dx++) begin
          d[0] = dx; d[1] = dy; d[2] = dz;
          for (int i = 0; i < 3; i++) w[i] = wrap_mod(tl[i] + d[i], pr[i]);
          idx = 32'((w[2] * pr[1] + w[1]) * pr[0] + w[0]);
          h[0] = lowbias(v.sd + idx);
          h[1] = lowbias(h[0]);
          h[2] = lowbias(h[1]);
          sq = 0;
          for (int i = 0; i < 3; i++) begin
            diff = fr[i] - d[i] * (64'd1 << FRAC_BITS) - (h[i] >> (32 - FRAC_BITS));
            a = (diff < 0) ? -diff : diff;
            sq += a * a;
          end
          if (sq < bestsq) bestsq = sq;
        end
    rem = bestsq; root = 0; bit_ = 64'd1 << 62;
    while (bit_ > rem) bit_ >>= 2;
    while (bit_ != 0) begin
      if (rem >= root + bit_) begin
        rem -= root + bit_;
        root = (root >> 1) + bit_;
      end else root >>= 1;
      bit_ >>= 2;
    end
    if (root > (64'd1 << FRAC_BITS)) root = 64'd1 << FRAC_BITS;
    return OUT_W'(root);
  endfunction

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  // driver: one nonblocking write to start per falling edge
  always @(negedge clk) begin
    if (!rst && feeding && voxel_q.size() > 0 && !hold_send &&
        $urandom_range(99) >= send_idle) begin
      voxel_t v;
      v = voxel_q.pop_front();
      {pos_x, pos_y, pos_z, seed} <= {v.px, v.py, v.pz, v.sd};
      {period_x, period_y, period_z} <= {v.prx, v.pry, v.prz};
      start <= 1'b1;
    end else start <= 1'b0;
  end

  // predictor on accepted word, then compare strobed results
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        voxel_t v;
        v = '{pos_x, pos_y, pos_z, seed, period_x, period_y, period_z};
        dist_q.push_back(nearest_feature(v));
      end
      if (done) begin
        if (dist_q.size() == 0) report("result with none expected");
        else begin
          logic [OUT_W-1:0] e;
          e = dist_q.pop_front();
          if (nearest_distance !== e)
            report($sformatf("nearest_distance %0d, expected %0d", nearest_distance, e));
        end
      end
    end
  end

  function automatic voxel_t rand_voxel();
    voxel_t v;
    int mode;
    mode = $urandom_range(9);
    v.px = POS_W'($urandom); v.py = POS_W'($urandom); v.pz = POS_W'($urandom);
    v.sd = $urandom;
    v.prx = PER_W'($urandom); v.pry = PER_W'($urandom); v.prz = PER_W'($urandom);
    if (mode < 6) begin
      // legal periods, half of them small so wraps happen often
      v.prx = (mode < 3) ? PER_W'($urandom_range(1, 8)) : PER_W'($urandom_range(1, 256));
      v.pry = (mode < 3) ? PER_W'($urandom_range(1, 8)) : PER_W'($urandom_range(1, 256));
      v.prz = (mode < 3) ? PER_W'($urandom_range(1, 8)) : PER_W'($urandom_range(1, 256));
    end else if (mode == 6) begin
      v.prx = '0; v.pry = PER_W'($urandom_range(0, 1)); v.prz = '0;
    end
    return v;
  endfunction

  task automatic drain();
    wait (voxel_q.size() == 0);
    @(posedge clk);
    while (dist_q.size() > 0) @(posedge clk);
  endtask

  initial begin
    voxel_t v;
    logic [POS_W-1:0] edges[4] = '{24'h0, 24'hFFFFFF, 24'h00FFFF, 24'hFF0000};
    logic [PER_W-1:0] pers[5] = '{9'd0, 9'd1, 9'd256, 9'd511, 9'd3};
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    // directed: corner positions, zero / max / oversize periods, seed extremes
    for (int i = 0; i < 20; i++) begin
      v.px = edges[i % 4]; v.py = edges[(i / 4) % 4]; v.pz = edges[(i + 1) % 4];
      v.sd = (i % 2) ? 32'hFFFFFFFF : 32'h0;
      v.prx = pers[i % 5]; v.pry = pers[(i + 2) % 5]; v.prz = pers[(i + 4) % 5];
      voxel_q.push_back(v);
    end
    feeding = 1;
    drain();
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 14 : (ph == 1) ? 74 : 0;
      for (int i = 0; i < 530; i++) voxel_q.push_back(rand_voxel());
      if (ph == 1) begin
        // hold off until the pipe is empty mid-phase
        wait (voxel_q.size() < 265);
        hold_send = 1;
        while (dist_q.size() > 0) @(posedge clk);
        hold_send = 0;
      end
      drain();
    end
    repeat (80) @(posedge clk);
    if (errors == 0 && dist_q.size() == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end
endmodule
